// ----- hdl/pli_pkg.sv -----
// shared types and constants for the positional list insert/delete unit
// no dependencies; used by the controller, the datapath and the top level
package pli_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int EXT_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/positional_list_insert_delete_unit.sv -----
// top level of the positional list insert/delete unit
// depends on pli_pkg, pli_ctrl and pli_dpath
//
// keeps an ordered list of up to CAPACITY signed 32-bit words in a chain of
// register cells plus a fill count; an insert places a word at a 1-based
// position from 1 to count+1 and moves later entries up one place, failing
// when the position is out of range or the list is full; a delete takes out
// the word at a position from 1 to count, returns it and moves later entries
// down, failing when the position is out of range; every item gives exactly
// one result with the success flag, the removed word (zero unless a delete
// succeeded) and the fill count after the operation, masked to 5 bits;
// an item is first captured, then every cell of the chain loads its new value
// at once, as soon as the result register is free; the controller accepts the
// next item while a result still waits in the output register, and it stalls
// the update only until that result is taken
module positional_list_insert_delete_unit
    import pli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item in
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_insert_value,
    // item out
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_accepted,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [POS_W-1:0]         o_fill_level
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing: capture, then update once the result register is free
    pli_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // list cells, count and result register
    pli_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_insert_value  (i_insert_value),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_accepted      (o_accepted),
        .o_removed_value (o_removed_value),
        .o_fill_level    (o_fill_level)
    );

endmodule

// ----- hdl/pli_ctrl.sv -----
// controller for the positional list unit: captures an item, then fires the list update
// depends on pli_pkg
module pli_ctrl
    import pli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/pli_dpath.sv -----
// datapath: item register, chain of list cells, fill count and result register
// depends on pli_pkg
module pli_dpath
    import pli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_opcode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_insert_value,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic                     o_accepted,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [POS_W-1:0]         o_fill_level
);

    // captured item
    logic                     r_opcode;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_val;

    logic signed [DATA_W-1:0] r_cells [CAPACITY];
    logic signed [DATA_W-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic                     r_out_valid;
    logic                     r_accepted;
    logic signed [DATA_W-1:0] r_removed;

    logic [EXT_W-1:0] w_pos_ext;
    logic [EXT_W-1:0] w_pos_m1;
    logic [EXT_W-1:0] w_cnt_ext;
    logic [IDX_W-1:0] w_idx;
    logic             w_ins_ok;
    logic             w_del_ok;

    assign w_pos_ext = EXT_W'(r_pos);
    assign w_pos_m1  = w_pos_ext - EXT_W'(1);
    assign w_cnt_ext = EXT_W'(r_count);
    assign w_idx     = w_pos_m1[IDX_W-1:0];

    assign w_ins_ok = (r_opcode == OP_INSERT) && (r_pos != '0)
                   && (w_pos_ext <= w_cnt_ext + EXT_W'(1))
                   && (r_count < CNT_W'(CAPACITY));
    assign w_del_ok = (r_opcode == OP_DELETE) && (r_pos != '0)
                   && (w_pos_ext <= w_cnt_ext);

    // each cell takes its own value, its lower or upper neighbor, or the new word
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (w_ins_ok) begin
                if (EXT_W'(i) == w_pos_m1) begin
                    n_cells[i] = r_val;
                end else if (EXT_W'(i) > w_pos_m1 && i > 0) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (w_del_ok) begin
                if (EXT_W'(i) >= w_pos_m1 && i < CAPACITY - 1) begin
                    n_cells[i] = r_cells[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        priority if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del_ok) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= i_opcode;
            r_pos    <= i_position;
            r_val    <= i_insert_value;
        end
        if (i_cmd.execute) begin
            r_cells    <= n_cells;
            r_accepted <= w_ins_ok || w_del_ok;
            r_removed  <= w_del_ok ? r_cells[w_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [EXT_W-1:0] w_fill_ext;
    assign w_fill_ext = EXT_W'(r_count);

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_removed_value   = r_removed;
    assign o_fill_level      = w_fill_ext[POS_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |-> o_status.out_free)
        else $error("update fired while result register still held");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> r_out_valid)
        else $error("update without a result");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && w_del_ok) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("successful delete did not shrink the list");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// testbench for positional_list_insert_delete_unit: a directed table, then random
// insert/delete traffic with random idling on both sides; depends on pli_pkg and the unit
module tb;
    import pli_pkg::*;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] removed;
        logic [POS_W-1:0]         fill;
    } t_list_result;

    // one line of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_opcode                  op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        t_list_result             want;
    } t_stim_row;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_opcode       = 1'b0;
    logic [POS_W-1:0]         i_position     = '0;
    logic signed [DATA_W-1:0] i_insert_value = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic                     o_accepted;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [POS_W-1:0]         o_fill_level;

    // shadow copy of the list, advanced once per accepted item
    logic signed [DATA_W-1:0] shadow_words [CAPACITY];
    int                       shadow_len     = 0;
    t_list_result             pending_results [$];
    t_stim_row                directed_rows [$];
    int                       mismatch_count = 0;
    int                       results_taken  = 0;
    logic                     sender_burst   = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    positional_list_insert_delete_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_position     (i_position),
        .i_insert_value (i_insert_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_accepted     (o_accepted),
        .o_removed_value(o_removed_value),
        .o_fill_level   (o_fill_level)
    );

    // insert shifts the tail up, delete shifts it down; failures leave the list alone
    function automatic t_list_result apply_list_op(input t_opcode op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        t_list_result r;
        int           p;
        int           j;
        r = '0;
        p = pos;
        if (op == OP_INSERT) begin
            if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY) begin
                for (j = shadow_len; j >= p; j--)
                    shadow_words[j] = shadow_words[j - 1];
                shadow_words[p - 1] = val;
                shadow_len++;
                r.accepted = 1'b1;
            end
        end else if (p >= 1 && p <= shadow_len) begin
            r.removed = shadow_words[p - 1];
            for (j = p; j < shadow_len; j++)
                shadow_words[j - 1] = shadow_words[j];
            shadow_len--;
            r.accepted = 1'b1;
        end
        r.fill = POS_W'(shadow_len);
        return r;
    endfunction

    task automatic add_row(input t_opcode op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val, input logic typed,
                           input logic acc, input logic signed [DATA_W-1:0] rem,
                           input logic [POS_W-1:0] fill);
        t_stim_row row;
        row.op            = op;
        row.pos           = pos;
        row.val           = val;
        row.typed         = typed;
        row.want.accepted = acc;
        row.want.removed  = rem;
        row.want.fill     = fill;
        directed_rows.push_back(row);
    endtask

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input t_opcode op, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val, input logic typed,
                             input t_list_result want);
        int           gap;
        logic         go;
        t_list_result predicted;
        gap = sender_burst ? 0 : $urandom_range(7, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_position     <= pos;
        i_insert_value <= val;
        // stall is sampled mid-cycle so the edge itself carries no race
        do begin
            @(negedge i_clk);
            go = !o_stall;
            @(posedge i_clk);
        end while (!go);
        predicted = apply_list_op(op, pos, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stimulus: reset, directed table, then random traffic
    initial begin : item_source
        t_opcode                  op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     filling;
        int                       hi;
        int                       k;
        t_list_result             none;
        none    = '0;
        filling = 1'b1;

        // empty list: every delete fails, inserts only at position one
        add_row(OP_DELETE, 5'd1,  32'sd0,           1'b1, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd0,  32'sd5,           1'b1, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd2,  32'sd5,           1'b1, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd1,  32'sh7FFF_FFFF,   1'b1, 1'b1, 32'sd0, 5'd1);
        add_row(OP_INSERT, 5'd2,  32'sh8000_0000,   1'b1, 1'b1, 32'sd0, 5'd2);
        // delete past the end and at position zero
        add_row(OP_DELETE, 5'd3,  32'sd0,           1'b1, 1'b0, 32'sd0, 5'd2);
        add_row(OP_DELETE, 5'd0,  32'sd0,           1'b1, 1'b0, 32'sd0, 5'd2);
        add_row(OP_INSERT, 5'd1,  -32'sd1,          1'b1, 1'b1, 32'sd0, 5'd3);
        // fill up to capacity at front, back and middle positions
        add_row(OP_INSERT, 5'd4,  32'sd0,           1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd2,  32'sd1,           1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd1,  32'sh5555_5555,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd7,  32'shAAAA_AAAA,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd3,  32'sh1234_5678,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd9,  32'shFEDC_BA98,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd5,  32'sh7FFF_FFFE,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd11, 32'sh8000_0001,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd6,  32'sh00FF_00FF,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd13, 32'shFF00_FF00,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd1,  32'sh0F0F_0F0F,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd15, 32'shF0F0_F0F0,   1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_INSERT, 5'd8,  32'sh3C3C_3C3C,   1'b0, 1'b0, 32'sd0, 5'd0);
        // full list: inserts fail at legal positions, then one bad and two good deletes
        add_row(OP_INSERT, 5'd17, 32'sd9,           1'b1, 1'b0, 32'sd0, 5'd16);
        add_row(OP_INSERT, 5'd1,  32'sd9,           1'b1, 1'b0, 32'sd0, 5'd16);
        add_row(OP_DELETE, 5'd31, 32'sd0,           1'b1, 1'b0, 32'sd0, 5'd16);
        add_row(OP_DELETE, 5'd16, 32'sd0,           1'b0, 1'b0, 32'sd0, 5'd0);
        add_row(OP_DELETE, 5'd1,  32'sd0,           1'b0, 1'b0, 32'sd0, 5'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
                      directed_rows[r].typed, directed_rows[r].want);

        // random walk of the fill level between empty and full
        for (k = 0; k < 850; k++) begin
            sender_burst = (k % 200) < 40;
            if (shadow_len == CAPACITY && $urandom_range(3, 0) == 0)
                filling = 1'b0;
            else if (shadow_len == 0)
                filling = 1'b1;
            else if ($urandom_range(59, 0) == 0)
                filling = !filling;

            op = (($urandom_range(99, 0) < 80) == filling) ? OP_INSERT : OP_DELETE;
            hi = (op == OP_INSERT) ? shadow_len + 1 : shadow_len;
            // mostly legal positions, some anywhere in the field
            if (hi == 0 || $urandom_range(99, 0) < 15)
                pos = POS_W'($urandom_range(31, 0));
            else
                pos = POS_W'($urandom_range(hi, 1));

            case ($urandom_range(19, 0))
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = '0;
                3:       val = '1;
                default: val = $urandom;
            endcase
            send_item(op, pos, val, 1'b0, none);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        // then idle on to catch a stray result
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, one long hold-off, compare against oldest pending
    initial begin : result_sink
        int           hold;
        logic         got;
        t_list_result seen;
        t_list_result want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_taken == 300)
                hold = 80;
            else if ((results_taken % 200) < 70)
                hold = 0;
            else
                hold = $urandom_range(7, 0);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got           = o_valid;
                seen.accepted = o_accepted;
                seen.removed  = o_removed_value;
                seen.fill     = o_fill_level;
                @(posedge i_clk);
            end while (!got);
            results_taken++;

            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no result, actual accepted=%0b removed=%0d fill=%0d",
                         $time, seen.accepted, seen.removed, seen.fill);
            end else begin
                want = pending_results.pop_front();
                if (seen.accepted !== want.accepted) begin
                    mismatch_count++;
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, want.accepted, seen.accepted);
                end
                if (seen.removed !== want.removed) begin
                    mismatch_count++;
                    $display("%0t: removed_value expected %0d actual %0d",
                             $time, want.removed, seen.removed);
                end
                if (seen.fill !== want.fill) begin
                    mismatch_count++;
                    $display("%0t: fill_level expected %0d actual %0d",
                             $time, want.fill, seen.fill);
                end
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
